// ===== sv/matrix3_inverse_assert.svh =====
// Assertion macros for the 3x3 inverse block.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH
`ifndef SYNTH
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define M3I_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg)
`define M3I_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/m3inv_pkg.sv =====
`default_nettype none
package m3inv_pkg;
  localparam int unsigned ENTRY_W   = 32;
  localparam int unsigned N_ENT     = 9;
  localparam int unsigned COF_W     = 65;
  localparam int unsigned DET_W     = 100;
  localparam int unsigned LO_W      = 33;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned USER_SING = 0;
  localparam int unsigned USER_OVF  = 1;

  // Entry indexes of cofactor k = m[p]*m[q] - m[r]*m[s]; j selects p, q, r, s.
  function automatic logic [3:0] cof_idx(input int k, input int j);
    logic [15:0] row;
    unique case (k)
      0: row = 16'h4857;
      1: row = 16'h2718;
      2: row = 16'h1524;
      3: row = 16'h5638;
      4: row = 16'h0826;
      5: row = 16'h2305;
      6: row = 16'h3746;
      7: row = 16'h1607;
      default: row = 16'h0413;
    endcase
    unique case (j)
      0: cof_idx = row[15:12];
      1: cof_idx = row[11:8];
      2: cof_idx = row[7:4];
      default: cof_idx = row[3:0];
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== sv/matrix3_inverse.sv =====
// 3x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// One matrix enters per word on the slave stream (s_axis_*); its inverse
// leaves as one word on the master stream (m_axis_*), in input order.
// Inputs are nine 32-bit entries by rows; outputs are nine 32-bit entries
// by rows plus two flags in tuser: singular (determinant zero, identity
// returned) and overflow (some entry saturated).
// The pipeline has 38 register stages: four stages form the products,
// cofactors and determinant, one stage prepares magnitudes, 32 stages
// run a restoring divider one quotient bit per stage for all nine
// entries in parallel, and one stage saturates into the output register.
// Throughput is one matrix per cycle while the receiver accepts words;
// the divider stages set the latency.
// Every stage has its own valid bit and advances when the stage after it is
// empty or advancing, so a stall of the receiver fills empty stages first
// and s_axis_tready falls only when every stage holds a word.
// Reset clears all valid bits; the pipeline is empty and ready afterward.
`default_nettype none
`include "matrix3_inverse_assert.svh"
module matrix3_inverse #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, 32 bits each from bit 0 up
  input  wire logic [287:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, 32 bits each from bit 0 up
  output logic [287:0]      m_axis_tdata,
  // singular, overflow from bit 0 up
  output logic [1:0]        m_axis_tuser
);
  localparam int unsigned EW = m3inv_pkg::ENTRY_W;
  localparam int unsigned NE = m3inv_pkg::N_ENT;
  localparam int unsigned CW = m3inv_pkg::COF_W;
  localparam int unsigned DW = m3inv_pkg::DET_W;
  localparam int unsigned LW = m3inv_pkg::LO_W;
  localparam int unsigned DS = m3inv_pkg::DIV_STEPS;
  localparam int unsigned NW = CW + 2 * FRAC_BITS;

  // Stall chain
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic vd_q [DS+1];
  logic en1, en2, en3, en4, en_o;
  logic en_d [DS+1];

  always_comb begin
    en_o = !vo_q || m_axis_tready;
    en_d[DS] = !vd_q[DS] || en_o;
    for (int s = DS - 1; s >= 0; s--) begin
      en_d[s] = !vd_q[s] || en_d[s+1];
    end
    en4 = !v4_q || en_d[0];
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
      for (int s = 0; s <= DS; s++) vd_q[s] <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en_d[0]) vd_q[0] <= v4_q;
      for (int s = 1; s <= DS; s++) begin
        if (en_d[s]) vd_q[s] <= vd_q[s-1];
      end
      if (en_o) vo_q <= vd_q[DS];
    end
  end

  // Stage 1: the eighteen entry products
  logic signed [EW-1:0] m_in [NE];
  logic signed [2*EW-1:0] pp_q [NE];
  logic signed [2*EW-1:0] pn_q [NE];
  logic signed [EW-1:0] abc1_q [3];
  logic signed [EW-1:0] abc2_q [3];

  always_comb begin
    for (int k = 0; k < NE; k++) m_in[k] = s_axis_tdata[k*EW +: EW];
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int k = 0; k < NE; k++) begin
        pp_q[k] <= m_in[m3inv_pkg::cof_idx(k, 0)] * m_in[m3inv_pkg::cof_idx(k, 1)];
        pn_q[k] <= m_in[m3inv_pkg::cof_idx(k, 2)] * m_in[m3inv_pkg::cof_idx(k, 3)];
      end
      for (int j = 0; j < 3; j++) abc1_q[j] <= m_in[j];
    end
  end

  // Stage 2: cofactors, exact
  logic signed [CW-1:0] cof2_q [NE];
  logic signed [CW-1:0] cof3_q [NE];
  logic signed [CW-1:0] cof4_q [NE];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int k = 0; k < NE; k++) begin
        cof2_q[k] <= CW'(pp_q[k]) - CW'(pn_q[k]);
      end
      abc2_q <= abc1_q;
    end
  end

  // Stage 3: determinant partial products, each cofactor split in two halves
  logic signed [2*EW-1:0]   phi_q [3];
  logic signed [LW+EW:0]    plo_q [3];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int j = 0; j < 3; j++) begin
        phi_q[j] <= $signed(cof2_q[3*j][CW-1:LW]) * abc2_q[j];
        plo_q[j] <= $signed({1'b0, cof2_q[3*j][LW-1:0]}) * abc2_q[j];
      end
      cof3_q <= cof2_q;
    end
  end

  // Stage 4: determinant
  logic signed [DW-1:0] det_sum;
  logic signed [DW-1:0] det4_q;

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (DW'(phi_q[j]) <<< LW) + DW'(plo_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      det4_q <= det_sum;
      cof4_q <= cof3_q;
    end
  end

  // Divider stage 0 takes magnitudes. A quotient of 2^32 or more is caught
  // here, so only the low 32 quotient bits go through the divider.
  logic [DW-1:0] rem_q  [DS+1][NE];
  logic [EW-1:0] w_q    [DS+1][NE];
  logic          neg_q  [DS+1][NE];
  logic          pov_q  [DS+1][NE];
  logic [DW-1:0] dabs_q [DS+1];
  logic          sing_q [DS+1];

  logic [DW-1:0] dabs0;
  logic [CW-1:0] cabs0 [NE];
  logic [NW-1:0] num0  [NE];

  always_comb begin
    dabs0 = det4_q[DW-1] ? DW'(-det4_q) : DW'(det4_q);
    for (int k = 0; k < NE; k++) begin
      cabs0[k] = cof4_q[k][CW-1] ? CW'(-cof4_q[k]) : CW'(cof4_q[k]);
      num0[k]  = {cabs0[k], {(2*FRAC_BITS){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d[0]) begin
      dabs_q[0] <= dabs0;
      sing_q[0] <= (det4_q == '0);
      for (int k = 0; k < NE; k++) begin
        rem_q[0][k] <= DW'(num0[k][NW-1:DS]);
        w_q[0][k]   <= num0[k][DS-1:0];
        neg_q[0][k] <= (cof4_q[k][CW-1] ^ det4_q[DW-1]) && (cof4_q[k] != '0);
        pov_q[0][k] <= DW'(num0[k][NW-1:DS]) >= dabs0;
      end
    end
  end

  // Restoring division, one quotient bit per stage; w shifts the dividend
  // bits out at the top and the quotient bits in at the bottom.
  for (genvar s = 1; s <= DS; s++) begin : g_div
    logic [DW-1:0] trial [NE];
    logic          ge    [NE];
    always_comb begin
      for (int k = 0; k < NE; k++) begin
        trial[k] = {rem_q[s-1][k][DW-2:0], w_q[s-1][k][EW-1]};
        ge[k]    = trial[k] >= dabs_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_d[s]) begin
        dabs_q[s] <= dabs_q[s-1];
        sing_q[s] <= sing_q[s-1];
        for (int k = 0; k < NE; k++) begin
          rem_q[s][k] <= ge[k] ? trial[k] - dabs_q[s-1] : trial[k];
          w_q[s][k]   <= {w_q[s-1][k][EW-2:0], ge[k]};
          neg_q[s][k] <= neg_q[s-1][k];
          pov_q[s][k] <= pov_q[s-1][k];
        end
      end
    end
  end

  // Output stage: sign, saturation, identity for a singular matrix
  localparam logic [EW-1:0] ONE     = EW'(1) << FRAC_BITS;
  localparam logic [EW-1:0] POS_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] NEG_MAX = {1'b1, {(EW-1){1'b0}}};

  logic [EW-1:0] lim   [NE];
  logic          sat   [NE];
  logic [EW-1:0] rval  [NE];
  logic [287:0]  data_d;
  logic          ovf_d;
  logic [287:0]  data_q;
  logic [1:0]    user_q;

  always_comb begin
    ovf_d = 1'b0;
    for (int k = 0; k < NE; k++) begin
      lim[k] = neg_q[DS][k] ? NEG_MAX : POS_MAX;
      sat[k] = pov_q[DS][k] || (w_q[DS][k] > lim[k]);
      rval[k] = sat[k] ? lim[k] : (neg_q[DS][k] ? -w_q[DS][k] : w_q[DS][k]);
      if (sing_q[DS]) begin
        rval[k] = (k == 0 || k == 4 || k == 8) ? ONE : '0;
      end else begin
        ovf_d = ovf_d | sat[k];
      end
      data_d[k*EW +: EW] = rval[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      data_q <= data_d;
      user_q[m3inv_pkg::USER_SING] <= sing_q[DS];
      user_q[m3inv_pkg::USER_OVF]  <= ovf_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

  `M3I_ASSERT(a_sing_no_ovf, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[m3inv_pkg::USER_SING] |-> !m_axis_tuser[m3inv_pkg::USER_OVF], "singular word flags overflow")
  `M3I_ASSERT(a_sing_ident, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[m3inv_pkg::USER_SING] |-> (m_axis_tdata[EW-1:0] == ONE) && (m_axis_tdata[2*EW-1:EW] == '0), "singular word is not identity")
  `M3I_ASSERT(a_ready_full, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && v1_q, "input stalled while pipeline has room")
  `M3I_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid || !$past(rst_ni), "output valid right after reset")
endmodule
`default_nettype wire
